@@ rtl/swm_pkg.sv @@
// Package for the seed word mixer: field widths, action codes and the
// fixed reset constants of the south and east chains. No dependencies.
package swm_pkg;

  localparam int unsigned WordWidth   = 64;
  localparam int unsigned ActionWidth = 2;

  typedef logic [WordWidth-1:0] word_t;

  // Action codes carried by an input transaction; code 3 is unused.
  typedef enum logic [ActionWidth-1:0] {
    ACT_SOUTH   = 2'd0,
    ACT_EAST    = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  // Reset words of each chain. The first chain word is never read by a
  // round, so only the second, third and fourth words are kept.
  localparam word_t SouthInitB = 64'h38d35226195ddb49;
  localparam word_t SouthInitC = 64'hadeb4f5fc2fe50ee;
  localparam word_t SouthInitD = 64'h096ed738a88b61c8;
  localparam word_t EastInitB  = 64'h973672f11a2ddd91;
  localparam word_t EastInitC  = 64'hc19950208bc3a7cf;
  localparam word_t EastInitD  = 64'hd378563e9631242d;

endpackage

@@ rtl/swm_in_if.sv @@
// Input channel of the seed word mixer: valid/ready with action and word.
// Depends on swm_pkg for the field widths.
interface swm_in_if;
  logic                               valid;
  logic                               ready;
  logic [swm_pkg::ActionWidth-1:0]    action;
  logic [swm_pkg::WordWidth-1:0]      data_word;

  modport source (output valid, output action, output data_word, input ready);
  modport sink   (input valid, input action, input data_word, output ready);
endinterface

@@ rtl/swm_out_if.sv @@
// Result channel of the seed word mixer: valid/ready with the mixed word.
// Depends on swm_pkg for the field width.
interface swm_out_if;
  logic                          valid;
  logic                          ready;
  logic [swm_pkg::WordWidth-1:0] mixed_word;

  modport source (output valid, output mixed_word, input ready);
  modport sink   (input valid, input mixed_word, output ready);
endinterface

@@ rtl/seed_word_mixer_top.sv @@
// Seed word mixer, top level.
// Depends on swm_pkg, swm_in_if and swm_out_if.
//
// Usage:
//   in_ch carries one transaction per item: an action (south mix, east mix,
//   restart) and a 64-bit seed word. out_ch returns the mixed word for each
//   south or east item, in order. Restart items and the unused action code
//   give no result; restart puts both chains back to their constants.
//   From input acceptance to result valid an item passes the input register,
//   then the round logic feeding the result register.
//   Throughput is one item per cycle while out_ch takes its results. The limit
//   is the chain update, whose next value feeds the round of the following item.
//   When out_ch stalls, the result register holds, the input register fills
//   behind it, and in_ch.ready drops only when both are occupied.
//   Reset (rst, synchronous) empties both registers and loads the chain
//   constants; the block accepts input in the first cycle after reset.
module seed_word_mixer_top (
  input  logic          clk,
  input  logic          rst,
  swm_in_if.sink        in_ch,
  swm_out_if.source     out_ch
);

  // Input register.
  logic                            s1_valid;
  logic [swm_pkg::ActionWidth-1:0] s1_action;
  swm_pkg::word_t                  s1_word;

  // Chain state (second, third and fourth words).
  swm_pkg::word_t south_b, south_c, south_d;
  swm_pkg::word_t east_b, east_c, east_d;

  // Result register.
  logic           res_valid;
  swm_pkg::word_t res_word;

  logic           advance;
  logic           res_valid_next;
  swm_pkg::word_t res_word_next;
  swm_pkg::word_t south_a_next, south_b_next, south_c_next, south_d_next;
  swm_pkg::word_t east_a_next, east_b_next, east_c_next, east_d_next;

  // The input register moves on when the result register is free or drained.
  assign advance     = !res_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || advance;

  assign out_ch.valid      = res_valid;
  assign out_ch.mixed_word = res_word;

  // Rounds of both chains on the registered word.
  always_comb begin
    south_a_next = (south_b + s1_word) ^ south_c;
    south_b_next = (south_c ^ south_d) - south_b;
    south_c_next = (south_d - south_c) ^ south_a_next;
    south_d_next = (south_b_next ^ south_a_next) + south_c_next;

    east_a_next = (east_b ^ s1_word) - east_c;
    east_b_next = (east_c + east_d) ^ east_b;
    east_c_next = (east_d + east_c) - east_a_next;
    east_d_next = (east_b_next ^ east_a_next) + east_c_next;
  end

  // Result selection for the item leaving the input register.
  always_comb begin
    res_valid_next = 1'b0;
    res_word_next  = south_a_next;
    unique case (s1_action)
      swm_pkg::ACT_SOUTH: begin
        res_valid_next = s1_valid;
        res_word_next  = south_a_next;
      end
      swm_pkg::ACT_EAST: begin
        res_valid_next = s1_valid;
        res_word_next  = east_a_next;
      end
      default: begin
        res_valid_next = 1'b0;
      end
    endcase
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_action <= in_ch.action;
      s1_word   <= in_ch.data_word;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid_next) begin
      res_word <= res_word_next;
    end
  end

  // Chain update when an item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      south_b <= swm_pkg::SouthInitB;
      south_c <= swm_pkg::SouthInitC;
      south_d <= swm_pkg::SouthInitD;
      east_b  <= swm_pkg::EastInitB;
      east_c  <= swm_pkg::EastInitC;
      east_d  <= swm_pkg::EastInitD;
    end else if (s1_valid && advance) begin
      unique case (s1_action)
        swm_pkg::ACT_SOUTH: begin
          south_b <= south_b_next;
          south_c <= south_c_next;
          south_d <= south_d_next;
        end
        swm_pkg::ACT_EAST: begin
          east_b <= east_b_next;
          east_c <= east_c_next;
          east_d <= east_d_next;
        end
        swm_pkg::ACT_RESTART: begin
          south_b <= swm_pkg::SouthInitB;
          south_c <= swm_pkg::SouthInitC;
          south_d <= swm_pkg::SouthInitD;
          east_b  <= swm_pkg::EastInitB;
          east_c  <= swm_pkg::EastInitC;
          east_d  <= swm_pkg::EastInitD;
        end
        default: begin
          // The unused code leaves both chains as they are.
        end
      endcase
    end
  end

endmodule

@@ dv/seed_word_mixer_top_test.sv @@
// Self-checking testbench for seed_word_mixer_top: directed and random south, east,
// restart and unused-code transactions, checked against a cycle-free chain model.
// Depends on swm_pkg, swm_in_if, swm_out_if and the seed_word_mixer_top RTL.
module seed_word_mixer_top_test;

  localparam logic [swm_pkg::ActionWidth-1:0] ActUnused = 2'd3;
  localparam int unsigned RandomItems = 1000;
  localparam int unsigned IdlePercent = 35;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [swm_pkg::ActionWidth-1:0] action;
    swm_pkg::word_t                  data_word;
  } seed_item_t;

  // Chain words that a round reads; the first word is only ever an output.
  typedef struct packed {
    swm_pkg::word_t b;
    swm_pkg::word_t c;
    swm_pkg::word_t d;
  } chain_t;

  logic clk;
  logic rst;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  seed_word_mixer_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  seed_item_t     seed_items[$];
  swm_pkg::word_t mixed_expected[$];
  chain_t         south_state;
  chain_t         east_state;
  int unsigned    n_items;
  int unsigned    n_accepted;
  int unsigned    n_checked;
  int unsigned    n_errors;
  int unsigned    n_per_action[4];
  int unsigned    idle_cycles;
  logic           timed_out;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Roll for an idle cycle; the quiet window keeps a stretch free of gaps.
  function automatic bit idle_roll(bit quiet);
    return !quiet && ($urandom_range(99) < IdlePercent);
  endfunction

  function automatic swm_pkg::word_t random_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Restore both chains to their reset constants.
  task automatic load_chains();
    south_state = '{b: swm_pkg::SouthInitB, c: swm_pkg::SouthInitC,
                    d: swm_pkg::SouthInitD};
    east_state  = '{b: swm_pkg::EastInitB,  c: swm_pkg::EastInitC,
                    d: swm_pkg::EastInitD};
  endtask

  // Apply one accepted transaction to the chains and, for a south or east mix, queue its mixed word.
  task automatic apply_item(input logic [swm_pkg::ActionWidth-1:0] act,
                            input swm_pkg::word_t w);
    swm_pkg::word_t na, nb, nc, nd;
    case (act)
      swm_pkg::ACT_SOUTH: begin
        na = (south_state.b + w) ^ south_state.c;
        nb = (south_state.c ^ south_state.d) - south_state.b;
        nc = (south_state.d - south_state.c) ^ na;
        nd = (nb ^ na) + nc;
        south_state = '{b: nb, c: nc, d: nd};
        mixed_expected.push_back(na);
      end
      swm_pkg::ACT_EAST: begin
        na = (east_state.b ^ w) - east_state.c;
        nb = (east_state.c + east_state.d) ^ east_state.b;
        nc = (east_state.d + east_state.c) - na;
        nd = (nb ^ na) + nc;
        east_state = '{b: nb, c: nc, d: nd};
        mixed_expected.push_back(na);
      end
      swm_pkg::ACT_RESTART: load_chains();
      default: ;
    endcase
  endtask

  // Input driver: updates the chain model on each accepted transaction and
  // presents the next pending item when the channel slot is free.
  always @(posedge clk) begin
    seed_item_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_item(in_ch.action, in_ch.data_word);
        n_per_action[in_ch.action]++;
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (seed_items.size() != 0 &&
            !idle_roll(n_accepted >= 300 && n_accepted < 500)) begin
          nxt = seed_items.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.action    <= nxt.action;
          in_ch.data_word <= nxt.data_word;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted mixed word with the oldest
  // expectation and drives a randomly stalling ready.
  always @(posedge clk) begin
    swm_pkg::word_t exp_word;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (mixed_expected.size() == 0) begin
          $display("%0t: unexpected mixed word %h with none pending", $time,
                   out_ch.mixed_word);
          n_errors++;
        end else begin
          exp_word = mixed_expected.pop_front();
          if (out_ch.mixed_word !== exp_word) begin
            $display("%0t: mixed_word mismatch: expected %h, actual %h", $time,
                     exp_word, out_ch.mixed_word);
            n_errors++;
          end
          n_checked++;
        end
      end
      out_ch.ready <= !idle_roll(n_checked >= 250 && n_checked < 450);
    end
  end

  // Watchdog on cycles where neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
      timed_out   <= 1'b0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        timed_out <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned roll;
    seed_item_t  item;

    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.action     = swm_pkg::ACT_SOUTH;
    in_ch.data_word  = '0;
    out_ch.ready     = 1'b0;
    n_accepted       = 0;
    n_checked        = 0;
    n_errors         = 0;
    n_per_action     = '{default: 0};
    load_chains();

    // Directed: field extremes, every action code, restart and unused code.
    seed_items.push_back('{swm_pkg::ACT_SOUTH,   64'h0});
    seed_items.push_back('{swm_pkg::ACT_SOUTH,   '1});
    seed_items.push_back('{swm_pkg::ACT_EAST,    64'h0});
    seed_items.push_back('{swm_pkg::ACT_EAST,    '1});
    seed_items.push_back('{swm_pkg::ACT_SOUTH,   64'h5555_5555_5555_5555});
    seed_items.push_back('{swm_pkg::ACT_EAST,    64'haaaa_aaaa_aaaa_aaaa});
    seed_items.push_back('{ActUnused,            '1});
    seed_items.push_back('{swm_pkg::ACT_SOUTH,   64'h8000_0000_0000_0001});
    seed_items.push_back('{ActUnused,            64'h0});
    seed_items.push_back('{swm_pkg::ACT_RESTART, '1});
    seed_items.push_back('{swm_pkg::ACT_SOUTH,   64'h0});
    seed_items.push_back('{swm_pkg::ACT_EAST,    64'h0});
    seed_items.push_back('{swm_pkg::ACT_RESTART, 64'h0});
    seed_items.push_back('{swm_pkg::ACT_RESTART, 64'h1234_5678_9abc_def0});
    seed_items.push_back('{swm_pkg::ACT_EAST,    64'h0000_0000_0000_0001});
    seed_items.push_back('{swm_pkg::ACT_EAST,    64'hffff_ffff_0000_0000});
    seed_items.push_back('{swm_pkg::ACT_SOUTH,   64'h0000_0000_ffff_ffff});
    seed_items.push_back('{ActUnused,            64'haaaa_aaaa_aaaa_aaaa});
    seed_items.push_back('{swm_pkg::ACT_SOUTH,   64'h7fff_ffff_ffff_ffff});

    // Random: mostly mixes, with occasional restarts and unused codes.
    repeat (RandomItems) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        item.action = swm_pkg::ACT_SOUTH;
      end else if (roll < 90) begin
        item.action = swm_pkg::ACT_EAST;
      end else if (roll < 96) begin
        item.action = swm_pkg::ACT_RESTART;
      end else begin
        item.action = ActUnused;
      end
      item.data_word = random_word();
      seed_items.push_back(item);
    end
    n_items = seed_items.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: every item accepted and every mixed word returned.
    while (!timed_out && (n_accepted != n_items || mixed_expected.size() != 0)) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    if (mixed_expected.size() != 0) begin
      $display("%0t: %0d mixed words never returned", $time, mixed_expected.size());
      n_errors++;
    end
    $display("Ran %0d transactions: %0d south, %0d east, %0d restart, %0d unused code.",
             n_accepted, n_per_action[swm_pkg::ACT_SOUTH],
             n_per_action[swm_pkg::ACT_EAST],
             n_per_action[swm_pkg::ACT_RESTART], n_per_action[ActUnused]);
    $display("Checked %0d mixed words, %0d errors.", n_checked, n_errors);
    if (!timed_out && n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/swm_pkg.sv
rtl/swm_in_if.sv
rtl/swm_out_if.sv
rtl/seed_word_mixer_top.sv
dv/seed_word_mixer_top_test.sv
